// ----- rtl/core/ptt_pkg.sv -----
// Shared types and constants for the periodic tick timer bank.
package ptt_pkg;

	// Slot storage limits
	localparam int SLOT_COUNT_DEF = 16;
	localparam int HW_SLOT_LIMIT  = 16;
	localparam int PERIOD_W       = 16;
	localparam int SLOT_W         = 4;

	localparam logic [PERIOD_W-1:0] CLEARED_VALUE = 16'hFFFF;

	// Request operation codes
	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_SUBMIT = 2'd1,
		MODE_CLEAR  = 2'd2
	} mode_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_NONE        = 2'd0,
		KIND_FIRED       = 2'd1,
		KIND_SUBMIT_OK   = 2'd2,
		KIND_SUBMIT_FULL = 2'd3
	} kind_t;

	// One slot in the counter memory
	typedef struct packed {
		logic [PERIOD_W-1:0] reload;
		logic [PERIOD_W-1:0] count;
	} slot_entry_t;

	// Result of one pass through the fire unit
	typedef struct packed {
		logic                fire;
		logic [PERIOD_W-1:0] next_count;
	} fire_result_t;

endpackage

// ----- rtl/core/periodic_tick_timer_bank_unit.sv -----
// Periodic tick timer bank: up to 16 slots served by one shared fire/decrement unit.
// A submit or clear request passes through ST_EXEC and gives its single result once
// the output register is free. A tick request visits each handed-out slot in index
// order (a registered read of the slot memory, then the fire check and write-back
// through the shared unit), then closes out in ST_FINISH. Fired slots come out one
// per result, the final one marked last; a tick that fires nothing returns one empty
// result. The walk pauses when a slot fires while an earlier fired slot is held back
// and the output register is still full. in_ready is high only between requests.
module periodic_tick_timer_bank_unit #(
	parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [ptt_pkg::PERIOD_W-1:0] period,
	input  logic [ptt_pkg::SLOT_W-1:0]   slot_select,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   result_kind,
	output logic [ptt_pkg::SLOT_W-1:0]   slot_number,
	output logic                         last_result
);

	localparam int CAP    = (SLOT_COUNT > ptt_pkg::HW_SLOT_LIMIT) ? ptt_pkg::HW_SLOT_LIMIT :
	                        ((SLOT_COUNT < 1) ? 1 : SLOT_COUNT);
	localparam int IDX_W  = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int USED_W = $clog2(CAP + 1);
	localparam logic [USED_W-1:0] CAP_U = USED_W'(CAP);
	localparam logic [ptt_pkg::SLOT_W:0] CAP_SEL = (ptt_pkg::SLOT_W + 1)'(CAP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	state_t                        state_q;
	logic [USED_W-1:0]             used_q;
	logic [CAP-1:0]                active_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          pend_q;
	logic [IDX_W-1:0]              pend_slot_q;
	logic                          out_valid_q;
	logic [1:0]                    kind_q;
	logic [ptt_pkg::SLOT_W-1:0]    slot_q;
	logic                          last_q;

	// Latched request
	logic [1:0]                    mode_q;
	logic [ptt_pkg::PERIOD_W-1:0]  period_q;
	logic [ptt_pkg::SLOT_W-1:0]    sel_q;

	// Slot memory
	ptt_pkg::slot_entry_t          mem [CAP];
	ptt_pkg::slot_entry_t          rdata_s1;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_waddr;
	ptt_pkg::slot_entry_t          mem_wdata;

	ptt_pkg::fire_result_t         fu_res;
	logic                          out_free;
	logic                          out_load;
	logic                          upd_go;
	logic                          walk_last;
	logic                          bank_full;
	logic                          sel_ok;
	logic [IDX_W-1:0]              used_idx;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign slot_number = slot_q;
	assign last_result = last_q;

	assign out_free  = !out_valid_q || out_ready;
	assign upd_go    = !fu_res.fire || !pend_q || out_free;
	assign walk_last = ((USED_W'(idx_q) + USED_W'(1)) == used_q);
	assign bank_full = (used_q >= CAP_U);
	assign sel_ok    = ({1'b0, sel_q} < CAP_SEL);
	assign used_idx  = used_q[IDX_W-1:0];

	// Output register loads a new result this cycle
	assign out_load = ((state_q == ST_EXEC) && (mode_q != ptt_pkg::MODE_TICK) && out_free) ||
	                  ((state_q == ST_UPDATE) && upd_go && fu_res.fire && pend_q) ||
	                  ((state_q == ST_FINISH) && out_free);

	// Shared fire/decrement unit
	ptt_fire_unit u_fire (
		.active (active_q[idx_q]),
		.entry  (rdata_s1),
		.result (fu_res)
	);

	// Memory write port select
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '{reload: rdata_s1.reload, count: fu_res.next_count};
		case (state_q)
			ST_UPDATE: begin
				mem_we = upd_go;
			end
			ST_EXEC: begin
				if (out_free) begin
					if (mode_q == ptt_pkg::MODE_SUBMIT && !bank_full) begin
						mem_we    = 1'b1;
						mem_waddr = used_idx;
						mem_wdata = '{reload: period_q, count: period_q};
					end else if (mode_q == ptt_pkg::MODE_CLEAR && sel_ok) begin
						mem_we    = 1'b1;
						mem_waddr = sel_q[IDX_W-1:0];
						mem_wdata = '{reload: ptt_pkg::CLEARED_VALUE,
						              count: ptt_pkg::CLEARED_VALUE};
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[idx_q];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q   <= mode;
			period_q <= period;
			sel_q    <= slot_select;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			active_q    <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_slot_q <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= ptt_pkg::KIND_NONE;
			slot_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (mode_q == ptt_pkg::MODE_TICK) begin
						state_q <= (used_q == '0) ? ST_FINISH : ST_READ;
					end else if (out_free) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
						if (mode_q == ptt_pkg::MODE_SUBMIT && !bank_full) begin
							kind_q             <= ptt_pkg::KIND_SUBMIT_OK;
							slot_q             <= ptt_pkg::SLOT_W'(used_idx);
							active_q[used_idx] <= 1'b1;
							used_q             <= used_q + USED_W'(1);
						end else begin
							slot_q <= '0;
							if (mode_q == ptt_pkg::MODE_SUBMIT) begin
								kind_q <= ptt_pkg::KIND_SUBMIT_FULL;
							end else begin
								kind_q <= ptt_pkg::KIND_NONE;
							end
							if (mode_q == ptt_pkg::MODE_CLEAR && sel_ok) begin
								active_q[sel_q[IDX_W-1:0]] <= 1'b0;
							end
						end
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_go) begin
						if (fu_res.fire) begin
							// Release the previous fired slot, hold this one back
							if (pend_q) begin
								kind_q      <= ptt_pkg::KIND_FIRED;
								slot_q      <= ptt_pkg::SLOT_W'(pend_slot_q);
								last_q      <= 1'b0;
							end
							pend_q      <= 1'b1;
							pend_slot_q <= idx_q;
						end
						if (walk_last) begin
							state_q <= ST_FINISH;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						last_q      <= 1'b1;
						if (pend_q) begin
							kind_q <= ptt_pkg::KIND_FIRED;
							slot_q <= ptt_pkg::SLOT_W'(pend_slot_q);
						end else begin
							kind_q <= ptt_pkg::KIND_NONE;
							slot_q <= '0;
						end
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_used_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CAP_U)
		else $error("slot count above capacity");

	a_no_pending_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pend_q)
		else $error("fired slot still held while idle");

	a_inactive_above_used: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q >> used_q) == '0)
		else $error("active slot beyond handed-out range");

	a_mid_fire_blocks_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == ptt_pkg::KIND_FIRED && !last_q) |-> state_q != ST_IDLE)
		else $error("tick walk ended with a non-final fired result outstanding");

endmodule

// ----- rtl/core/ptt_fire_unit.sv -----
// Shared per-slot fire check, reload and decrement unit.
module ptt_fire_unit (
	input  logic                  active,
	input  ptt_pkg::slot_entry_t  entry,
	output ptt_pkg::fire_result_t result
);

	logic [ptt_pkg::PERIOD_W-1:0] base;

	// Fire on an active slot at zero, reload, then count down with wrap
	always_comb begin
		result.fire       = active && (entry.count == '0);
		base              = result.fire ? entry.reload : entry.count;
		result.next_count = base - ptt_pkg::PERIOD_W'(1);
	end

endmodule
